FILE: rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the png scanline unfilter: filter codes,
// register indexes, pixel layout and default line store size.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

	// channel layout of one pixel, red in the low byte
	localparam int NUM_CH   = 4;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	typedef logic [7:0] byte_t;
	typedef logic [NUM_CH-1:0][7:0] pixel_t;

	// row filter codes
	localparam byte_t FILT_NONE  = 8'd0;
	localparam byte_t FILT_SUB   = 8'd1;
	localparam byte_t FILT_UP    = 8'd2;
	localparam byte_t FILT_AVG   = 8'd3;
	localparam byte_t FILT_PAETH = 8'd4;

	// configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = 2'd2;

	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 16;

	// default line store depth in pixels
	localparam int MAX_WIDTH_DEFAULT = 4096;

endpackage

`default_nettype wire

FILE: rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Reconstructs filtered png scanlines of 8-bit rgb or rgba pixels, one pixel
// per item, with four channel lanes and a merging stage.
// ----------------------------------------------------------------------------
// pipeline: an accepted pixel passes the line store read stage, then is
//   reconstructed into the output register, from which it can be taken
// throughput: one pixel per cycle unless the output stalls; the left pixel
//   loop closes inside the reconstruct stage and the line store takes one
//   read and one write a cycle
// reset: clears config (width 1, height 1, alpha on), counters, neighbor
//   pixels and valids; the line store is not cleared and needs no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter #(
	parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEFAULT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration
	input  wire                                cfg_write,
	input  wire [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [psu_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input items
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [7:0]                          filter_kind,
	input  wire [7:0]                          raw_red,
	input  wire [7:0]                          raw_green,
	input  wire [7:0]                          raw_blue,
	input  wire [7:0]                          raw_alpha,
	// result items
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic [7:0]                         alpha,
	output logic                               row_end,
	output logic                               image_end,
	output logic                               bad_filter
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = (AW + 1 > psu_pkg::WIDTH_W + 1) ? AW + 1 : psu_pkg::WIDTH_W + 1;
	localparam int HW = psu_pkg::HEIGHT_W + 1;

	// configuration registers
	logic [psu_pkg::WIDTH_W-1:0]  image_width_q;
	logic [psu_pkg::HEIGHT_W-1:0] image_height_q;
	logic                         has_alpha_q;

	// position counters
	logic [AW-1:0]                col_q;
	logic [psu_pkg::HEIGHT_W-1:0] row_q;

	// read stage
	logic                         valid_s1;
	psu_pkg::byte_t               kind_s1;
	psu_pkg::pixel_t              raw_s1;
	logic [AW-1:0]                col_s1;
	logic                         left_ok_s1;
	logic                         up_ok_s1;
	logic                         row_end_s1;
	logic                         image_end_s1;

	// neighbors carried from the previous pixel
	psu_pkg::pixel_t              left_q;
	psu_pkg::pixel_t              upleft_q;

	// output register
	logic                         out_valid_q;
	psu_pkg::pixel_t              pix_s2;
	logic                         row_end_s2;
	logic                         image_end_s2;
	logic                         bad_s2;

	logic                         in_accept;
	logic                         adv_s1;
	logic [CW-1:0]                width_eff;
	logic [HW-1:0]                height_eff;
	logic [CW-1:0]                col_next;
	logic [HW-1:0]                row_next;
	logic                         row_end_now;
	logic                         image_end_now;
	psu_pkg::pixel_t              up_rd;
	psu_pkg::pixel_t              up_pix;
	psu_pkg::pixel_t              left_pix;
	psu_pkg::pixel_t              upleft_pix;
	psu_pkg::pixel_t              lane_out;
	psu_pkg::pixel_t              result;
	logic                         bad_now;

	// handshake
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign in_accept = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= psu_pkg::WIDTH_W'(1);
			image_height_q <= psu_pkg::HEIGHT_W'(1);
			has_alpha_q    <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				psu_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[psu_pkg::WIDTH_W-1:0];
				psu_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[psu_pkg::HEIGHT_W-1:0];
				psu_pkg::REG_HAS_ALPHA:    has_alpha_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective width and height, clamped to the legal range
	always_comb begin
		width_eff = CW'(image_width_q);
		if (width_eff == '0) begin
			width_eff = CW'(1);
		end
		if (width_eff > CW'(MAX_WIDTH)) begin
			width_eff = CW'(MAX_WIDTH);
		end
		height_eff = HW'(image_height_q);
		if (height_eff == '0) begin
			height_eff = HW'(1);
		end
	end

	// end of row and image for the pixel being accepted
	assign col_next      = CW'(col_q) + CW'(1);
	assign row_next      = HW'(row_q) + HW'(1);
	assign row_end_now   = col_next >= width_eff;
	assign image_end_now = row_end_now && (row_next >= height_eff);

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (row_end_now) begin
				col_q <= '0;
				row_q <= image_end_now ? '0 : row_next[psu_pkg::HEIGHT_W-1:0];
			end else begin
				col_q <= col_next[AW-1:0];
			end
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1              <= filter_kind;
			raw_s1[psu_pkg::CH_RED]   <= raw_red;
			raw_s1[psu_pkg::CH_GREEN] <= raw_green;
			raw_s1[psu_pkg::CH_BLUE]  <= raw_blue;
			raw_s1[psu_pkg::CH_ALPHA] <= raw_alpha;
			col_s1               <= col_q;
			left_ok_s1           <= col_q != '0;
			up_ok_s1             <= row_q != '0;
			row_end_s1           <= row_end_now;
			image_end_s1         <= image_end_now;
		end
	end

	// previous scanline
	psu_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (col_q),
		.rd_data (up_rd),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (result)
	);

	// neighbors outside the image read as zero
	assign up_pix     = up_ok_s1 ? up_rd : '0;
	assign left_pix   = left_ok_s1 ? left_q : '0;
	assign upleft_pix = (left_ok_s1 && up_ok_s1) ? upleft_q : '0;

	// one lane per channel
	for (genvar ch = 0; ch < psu_pkg::NUM_CH; ch++) begin : g_lane
		psu_lane u_lane (
			.kind   (kind_s1),
			.raw    (raw_s1[ch]),
			.left   (left_pix[ch]),
			.up     (up_pix[ch]),
			.upleft (upleft_pix[ch]),
			.recon  (lane_out[ch])
		);
	end

	// merge lanes: zero on unknown filter, alpha dropped in rgb mode
	assign bad_now = kind_s1 > psu_pkg::FILT_PAETH;
	always_comb begin
		result = lane_out;
		if (!has_alpha_q) begin
			result[psu_pkg::CH_ALPHA] = 8'd0;
		end
		if (bad_now) begin
			result = '0;
		end
	end

	// neighbor registers follow each reconstructed pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (adv_s1) begin
			left_q   <= result;
			upleft_q <= up_pix;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pix_s2       <= result;
			row_end_s2   <= row_end_s1;
			image_end_s2 <= image_end_s1;
			bad_s2       <= bad_now;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = pix_s2[psu_pkg::CH_RED];
	assign green      = pix_s2[psu_pkg::CH_GREEN];
	assign blue       = pix_s2[psu_pkg::CH_BLUE];
	assign alpha      = pix_s2[psu_pkg::CH_ALPHA];
	assign row_end    = row_end_s2;
	assign image_end  = image_end_s2;
	assign bad_filter = bad_s2;

	// image end only ever falls on a row end
	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!image_end_s2 || row_end_s2))
		else $error("image end without row end");

	// unknown filter gives an all-zero pixel
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_s2) |-> (pix_s2 == '0))
		else $error("bad filter with nonzero channels");

	// a row end restarts the column counter
	a_row_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && row_end_now) |=> (col_q == '0))
		else $error("column counter not restarted after row end");

	// after an item the column counter sits inside the current width
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !cfg_write) |=> (CW'(col_q) < width_eff))
		else $error("column counter beyond image width");

	// read stage never advances into a full, stalled output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !adv_s1)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/psu_lane.sv
// ----------------------------------------------------------------------------
// psu_lane
// One channel of filter reconstruction: forms the predictor from the left,
// up and upper-left bytes and adds it to the filtered byte modulo 256.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_lane (
	input  wire psu_pkg::byte_t kind,
	input  wire psu_pkg::byte_t raw,
	input  wire psu_pkg::byte_t left,
	input  wire psu_pkg::byte_t up,
	input  wire psu_pkg::byte_t upleft,
	output psu_pkg::byte_t      recon
);

	logic        [8:0]  avg_sum;
	logic signed [10:0] sa, sb, sc;
	logic signed [10:0] pa_raw, pb_raw, pc_raw;
	logic        [10:0] da, db, dc;
	psu_pkg::byte_t     paeth;
	psu_pkg::byte_t     pred;

	// sum of left and up over nine bits, halved for the average
	assign avg_sum = {1'b0, left} + {1'b0, up};

	// paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
	always_comb begin
		sa = signed'({3'b000, left});
		sb = signed'({3'b000, up});
		sc = signed'({3'b000, upleft});
		pa_raw = sb - sc;
		pb_raw = sa - sc;
		pc_raw = sa + sb - sc - sc;
		da = (pa_raw < 0) ? unsigned'(-pa_raw) : unsigned'(pa_raw);
		db = (pb_raw < 0) ? unsigned'(-pb_raw) : unsigned'(pb_raw);
		dc = (pc_raw < 0) ? unsigned'(-pc_raw) : unsigned'(pc_raw);
		if (da <= db && da <= dc) begin
			paeth = left;
		end else if (db <= dc) begin
			paeth = up;
		end else begin
			paeth = upleft;
		end
	end

	// predictor select
	always_comb begin
		case (kind)
			psu_pkg::FILT_SUB:   pred = left;
			psu_pkg::FILT_UP:    pred = up;
			psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
			psu_pkg::FILT_PAETH: pred = paeth;
			default:             pred = 8'd0;
		endcase
	end

	assign recon = raw + pred;

endmodule

`default_nettype wire

FILE: rtl/psu_line_store.sv
// ----------------------------------------------------------------------------
// psu_line_store
// Previous scanline memory: one write and one registered read per cycle,
// with write-to-read forwarding when both hit the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_line_store #(
	parameter int DEPTH = psu_pkg::MAX_WIDTH_DEFAULT,
	parameter int AW    = 12
) (
	input  wire                    clk,
	input  wire                    rd_en,
	input  wire [AW-1:0]           rd_addr,
	output psu_pkg::pixel_t        rd_data,
	input  wire                    wr_en,
	input  wire [AW-1:0]           wr_addr,
	input  wire psu_pkg::pixel_t   wr_data
);

	psu_pkg::pixel_t mem [DEPTH];
	psu_pkg::pixel_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, forwarding a same-cycle write to that column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
